FILE: src/polygon_face_normal_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the polygon face normal block
// Implication and next-cycle checks on a clock with an active-low reset.
// ---------------------------------------------------------------------------
`ifndef POLYGON_FACE_NORMAL_ASSERT_SVH
`define POLYGON_FACE_NORMAL_ASSERT_SVH

// Same-cycle implication.
`define PFN_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("pfn assertion failed");

// Next-cycle implication.
`define PFN_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("pfn assertion failed");

`endif

FILE: src/pfn_pkg.sv
// ---------------------------------------------------------------------------
// pfn_pkg
// Shared types, codes and defaults of the polygon face normal block.
// ---------------------------------------------------------------------------
package pfn_pkg;

  localparam int DEF_VERTEX_DEPTH = 1024;
  localparam int DEF_COORD_WIDTH  = 24;
  localparam int DEF_NORMAL_WIDTH = 16;

  localparam int IDX_W   = 10;  // vertex_index field
  localparam int OPER_W  = 25;  // edge difference / sum after the drop
  localparam int MUL_W   = 32;  // shared multiplier operand width
  localparam int ACC_W   = 64;  // products and sums
  localparam int COUNT_W = 11;
  localparam int STEP_W  = 3;

  localparam logic [COUNT_W-1:0] COUNT_LIMIT = 11'd2047;
  localparam logic [COUNT_W-1:0] TRI_COUNT   = 11'd3;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_START  = 2'd1,
    ACT_VERTEX = 2'd2,
    ACT_END    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_VALID = 2'd0,
    ST_DEGEN = 2'd1,
    ST_SHORT = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_ABS,
    S_SCALE,
    S_SQRT,
    S_DINIT,
    S_DIV,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    M_EDGE,
    M_CLOSE,
    M_TRI,
    M_SQ
  } mul_mode_t;

  typedef struct packed {
    logic             wr;
    logic             rd;
    logic [IDX_W-1:0] index;
  } store_req_t;

endpackage

FILE: src/pfn_if.sv
// ---------------------------------------------------------------------------
// pfn_in_if / pfn_out_if
// Valid/ready channels for index words and normal result words.
// ---------------------------------------------------------------------------
interface pfn_in_if #(
  parameter int COORD_WIDTH = pfn_pkg::DEF_COORD_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic [1:0]                     action;
  logic [pfn_pkg::IDX_W-1:0]      vertex_index;
  logic signed [COORD_WIDTH-1:0]  coord_x;
  logic signed [COORD_WIDTH-1:0]  coord_y;
  logic signed [COORD_WIDTH-1:0]  coord_z;

  modport source (output valid, action, vertex_index, coord_x, coord_y, coord_z,
                  input ready);
  modport sink (input valid, action, vertex_index, coord_x, coord_y, coord_z,
                output ready);
endinterface

interface pfn_out_if #(
  parameter int NORMAL_WIDTH = pfn_pkg::DEF_NORMAL_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic signed [NORMAL_WIDTH-1:0] normal_x;
  logic signed [NORMAL_WIDTH-1:0] normal_y;
  logic signed [NORMAL_WIDTH-1:0] normal_z;
  logic [1:0]                     face_status;

  modport source (output valid, normal_x, normal_y, normal_z, face_status, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, face_status, output ready);
endinterface

FILE: src/pfn_store.sv
// ---------------------------------------------------------------------------
// pfn_store
// Coordinate store: one port, synchronous read, index folded to the depth.
// ---------------------------------------------------------------------------
module pfn_store #(
  parameter int VERTEX_DEPTH = pfn_pkg::DEF_VERTEX_DEPTH,
  parameter int DATA_W       = 3 * pfn_pkg::DEF_COORD_WIDTH
) (
  input  logic                clk,
  input  pfn_pkg::store_req_t req,
  input  logic [DATA_W-1:0]   wr_data,
  output logic [DATA_W-1:0]   rd_data
);

  localparam int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
  localparam int IW = pfn_pkg::IDX_W;

  logic [DATA_W-1:0] mem [VERTEX_DEPTH];
  logic [AW-1:0]     addr;

  // Index modulo depth by conditional subtraction of shifted depths.
  function automatic logic [IW-1:0] fold(input logic [IW-1:0] v);
    logic [IW-1:0] r;
    r = v;
    for (int k = IW - 1; k >= 0; k--) begin
      if ((longint'(VERTEX_DEPTH) << k) < (longint'(1) << IW)) begin
        if (r >= IW'(longint'(VERTEX_DEPTH) << k)) begin
          r = r - IW'(longint'(VERTEX_DEPTH) << k);
        end
      end
    end
    return r;
  endfunction

  assign addr = AW'(fold(req.index));

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[addr] <= wr_data;
    end
    if (req.rd) begin
      rd_data <= mem[addr];
    end
  end

endmodule

FILE: src/polygon_face_normal.sv
// ---------------------------------------------------------------------------
// polygon_face_normal
// Per-face unit normal of indexed polygons: coordinate store, shared
// multiplier for edge products, iterative square root and divider.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake        | word
//  in_ch    | in  | valid/ready      | action, vertex_index, coord_x/y/z
//  out_ch   | out | valid/ready      | normal_x/y/z, face_status
//  cfg_*    | in  | cfg_we strobe    | cfg_data = winding_ccw
//
//  Load and start-shape words are taken in idle. A vertex word reads the
//  store; for any vertex but the first of a face, three products then go
//  through the single multiplier.
//  An end-of-face word of three or more vertices runs the multiplies, the
//  normalizing shifts (one bit a cycle), the squares, the square root
//  iterations and a divide per component. A short face goes straight to
//  the result, a zero-length one ends early.
//  Reset is synchronous, active low; the coordinate store is not cleared.
//  A stalled result word holds in the output register while loads and
//  vertices keep coming; only the next face end waits for it.
// ---------------------------------------------------------------------------
module polygon_face_normal #(
  parameter int VERTEX_DEPTH = pfn_pkg::DEF_VERTEX_DEPTH,
  parameter int COORD_WIDTH  = pfn_pkg::DEF_COORD_WIDTH,
  parameter int NORMAL_WIDTH = pfn_pkg::DEF_NORMAL_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  pfn_in_if.sink    in_ch,
  pfn_out_if.source out_ch,
  input  logic      cfg_we,
  input  logic      cfg_data
);

  localparam int CW    = COORD_WIDTH;
  localparam int NW    = NORMAL_WIDTH;
  localparam int VW    = 3 * CW;
  localparam int DROP  = (CW > 24) ? CW - 24 : 0;
  localparam int QW    = NW + 1;
  localparam int BCW   = $clog2(QW);
  localparam int OW    = pfn_pkg::OPER_W;
  localparam int MW    = pfn_pkg::MUL_W;
  localparam int AW64  = pfn_pkg::ACC_W;
  localparam longint LIM = longint'(1) << (NW - 1);
  localparam logic [NW-1:0] MAXV = {1'b0, {(NW-1){1'b1}}};
  localparam logic [NW-1:0] MINV = {1'b1, {(NW-1){1'b0}}};

  // Edge difference or sum, floored down to the operand width.
  function automatic logic signed [OW-1:0] oper(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b,
                                                input logic is_sum);
    logic signed [CW:0] t;
    t = is_sum ? ({a[CW-1], a} + {b[CW-1], b}) : ({a[CW-1], a} - {b[CW-1], b});
    return OW'(t >>> DROP);
  endfunction

  // -------------------------------------------------------------------------
  // State
  // -------------------------------------------------------------------------
  pfn_pkg::state_t    state_r, state_nxt;
  pfn_pkg::mul_mode_t mode_r;
  pfn_pkg::status_t   stat_r, out_stat_r;

  logic [pfn_pkg::COUNT_W-1:0] count_r;
  logic                        abort_r;
  logic                        wind_r;
  logic                        face_tri_r;
  logic [pfn_pkg::STEP_W-1:0]  step_r;
  logic [1:0]                  pend_tgt_r;
  logic                        pend_sub_r;

  logic signed [CW-1:0] first_r [3][3];
  logic signed [CW-1:0] prev_r [3];
  logic signed [CW-1:0] cur_r [3];
  logic signed [AW64-1:0] sum_r [3];
  logic signed [AW64-1:0] prod_r;

  logic [AW64-1:0] mag_r [3];
  logic            neg_r [3];
  logic [AW64-1:0] sq_r;    // sum of squares, then the root's remainder
  logic [AW64-1:0] root_r;
  logic [AW64-1:0] sbit_r;
  logic [31:0]     len_r;
  logic [1:0]      ci_r;
  logic [AW64-1:0] rem_r;
  logic [AW64-1:0] dsh_r;
  logic [QW-1:0]   q_r;
  logic [BCW-1:0]  bcnt_r;
  logic [NW-1:0]   res_r [3];

  logic            out_valid_r;
  logic [NW-1:0]   out_x_r, out_y_r, out_z_r;

  // -------------------------------------------------------------------------
  // Coordinate store
  // -------------------------------------------------------------------------
  pfn_pkg::store_req_t store_req;
  logic [VW-1:0]       store_rd;
  logic signed [CW-1:0] rd_v [3];

  pfn_store #(
    .VERTEX_DEPTH (VERTEX_DEPTH),
    .DATA_W       (VW)
  ) u_store (
    .clk     (clk),
    .req     (store_req),
    .wr_data ({in_ch.coord_z, in_ch.coord_y, in_ch.coord_x}),
    .rd_data (store_rd)
  );

  assign rd_v[0] = store_rd[CW-1:0];
  assign rd_v[1] = store_rd[2*CW-1:CW];
  assign rd_v[2] = store_rd[3*CW-1:2*CW];

  // -------------------------------------------------------------------------
  // Handshake and decode
  // -------------------------------------------------------------------------
  logic             in_ready;
  logic             in_acc;
  logic             fin_go;
  pfn_pkg::action_t act;

  assign act    = pfn_pkg::action_t'(in_ch.action);
  assign in_acc = in_ch.valid && in_ready;

  always_comb begin
    in_ready  = (state_r == pfn_pkg::S_IDLE);
    fin_go    = (state_r == pfn_pkg::S_FIN) && (!out_valid_r || out_ch.ready);
    store_req.index = in_ch.vertex_index;
    store_req.wr    = in_ready && in_ch.valid && (act == pfn_pkg::ACT_LOAD);
    store_req.rd    = in_ready && in_ch.valid && (act == pfn_pkg::ACT_VERTEX) &&
                      !abort_r && (count_r < pfn_pkg::COUNT_LIMIT);
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.normal_x    = out_x_r;
  assign out_ch.normal_y    = out_y_r;
  assign out_ch.normal_z    = out_z_r;
  assign out_ch.face_status = out_stat_r;

  // -------------------------------------------------------------------------
  // Shared multiplier operand select
  // -------------------------------------------------------------------------
  logic signed [CW-1:0] eq [3];
  logic signed [OW-1:0] ta [3];
  logic signed [OW-1:0] tb [3];
  logic signed [MW-1:0] mul_a, mul_b;
  logic [1:0]           mul_tgt;
  logic                 mul_sub;
  logic [pfn_pkg::STEP_W-1:0] mul_last;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eq[i] = (mode_r == pfn_pkg::M_CLOSE) ? first_r[0][i] : cur_r[i];
      // counter-clockwise: a = c2 - c1, b = c0 - c1; clockwise swaps them
      ta[i] = wind_r ? oper(first_r[2][i], first_r[1][i], 1'b0)
                     : oper(first_r[0][i], first_r[1][i], 1'b0);
      tb[i] = wind_r ? oper(first_r[0][i], first_r[1][i], 1'b0)
                     : oper(first_r[2][i], first_r[1][i], 1'b0);
    end
  end

  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    mul_tgt  = 2'd0;
    mul_sub  = 1'b0;
    mul_last = (mode_r == pfn_pkg::M_TRI) ? 3'd6 : 3'd3;
    unique case (mode_r)
      pfn_pkg::M_EDGE, pfn_pkg::M_CLOSE: begin
        unique case (step_r)
          3'd0: begin
            mul_a = MW'(oper(prev_r[1], eq[1], 1'b0));
            mul_b = MW'(oper(prev_r[2], eq[2], 1'b1));
          end
          3'd1: begin
            mul_a   = MW'(oper(prev_r[2], eq[2], 1'b0));
            mul_b   = MW'(oper(prev_r[0], eq[0], 1'b1));
            mul_tgt = 2'd1;
          end
          default: begin
            mul_a   = MW'(oper(prev_r[0], eq[0], 1'b0));
            mul_b   = MW'(oper(prev_r[1], eq[1], 1'b1));
            mul_tgt = 2'd2;
          end
        endcase
      end
      pfn_pkg::M_TRI: begin
        unique case (step_r)
          3'd0: begin mul_a = MW'(ta[1]); mul_b = MW'(tb[2]); end
          3'd1: begin mul_a = MW'(ta[2]); mul_b = MW'(tb[1]); mul_sub = 1'b1; end
          3'd2: begin mul_a = MW'(ta[2]); mul_b = MW'(tb[0]); mul_tgt = 2'd1; end
          3'd3: begin
            mul_a = MW'(ta[0]); mul_b = MW'(tb[2]); mul_tgt = 2'd1; mul_sub = 1'b1;
          end
          3'd4: begin mul_a = MW'(ta[0]); mul_b = MW'(tb[1]); mul_tgt = 2'd2; end
          default: begin
            mul_a = MW'(ta[1]); mul_b = MW'(tb[0]); mul_tgt = 2'd2; mul_sub = 1'b1;
          end
        endcase
      end
      default: begin
        unique case (step_r)
          3'd0:    begin mul_a = MW'(mag_r[0][29:0]); mul_b = MW'(mag_r[0][29:0]); end
          3'd1:    begin mul_a = MW'(mag_r[1][29:0]); mul_b = MW'(mag_r[1][29:0]); end
          default: begin mul_a = MW'(mag_r[2][29:0]); mul_b = MW'(mag_r[2][29:0]); end
        endcase
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // Normalize helpers
  // -------------------------------------------------------------------------
  logic signed [AW64-1:0] vabs [3];
  logic                   all_zero, any_hi, any_29;
  logic                   sqrt_ge;
  logic [AW64-1:0]        root_step;
  logic                   div_ge;
  logic [QW-1:0]          qf;
  logic                   neg_sel;
  logic [AW64-1:0]        mag_sel;
  logic [NW-1:0]          res_val;
  logic [NW-1:0]          degen_x;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // clockwise polygons flip the Newell sums
      vabs[i] = (mode_r == pfn_pkg::M_CLOSE && !wind_r) ? -sum_r[i] : sum_r[i];
    end
    all_zero = (mag_r[0] == '0) && (mag_r[1] == '0) && (mag_r[2] == '0);
    any_hi   = (mag_r[0][AW64-1:30] != '0) || (mag_r[1][AW64-1:30] != '0) ||
               (mag_r[2][AW64-1:30] != '0);
    any_29   = mag_r[0][29] || mag_r[1][29] || mag_r[2][29];

    sqrt_ge   = sq_r >= (root_r + sbit_r);
    root_step = sqrt_ge ? ((root_r >> 1) + sbit_r) : (root_r >> 1);

    unique case (ci_r)
      2'd0:    begin mag_sel = mag_r[0]; neg_sel = neg_r[0]; end
      2'd1:    begin mag_sel = mag_r[1]; neg_sel = neg_r[1]; end
      default: begin mag_sel = mag_r[2]; neg_sel = neg_r[2]; end
    endcase

    div_ge = rem_r >= dsh_r;
    qf     = {q_r[QW-2:0], div_ge};
    if (neg_sel) begin
      res_val = (qf > QW'(LIM)) ? MINV : NW'(-qf);
    end else begin
      res_val = (qf > QW'(LIM - 1)) ? MAXV : NW'(qf);
    end

    degen_x = (face_tri_r || wind_r) ? MAXV : MINV;
  end

  // -------------------------------------------------------------------------
  // Next state
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pfn_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (act)
            pfn_pkg::ACT_VERTEX: begin
              if (!abort_r && count_r < pfn_pkg::COUNT_LIMIT) state_nxt = pfn_pkg::S_READ;
            end
            pfn_pkg::ACT_END: begin
              if (!abort_r) begin
                state_nxt = (count_r < pfn_pkg::TRI_COUNT) ? pfn_pkg::S_FIN : pfn_pkg::S_MUL;
              end
            end
            default: ;
          endcase
        end
      end
      pfn_pkg::S_READ: begin
        state_nxt = (count_r == '0) ? pfn_pkg::S_IDLE : pfn_pkg::S_MUL;
      end
      pfn_pkg::S_MUL: begin
        if (step_r == mul_last) begin
          unique case (mode_r)
            pfn_pkg::M_EDGE: state_nxt = pfn_pkg::S_IDLE;
            pfn_pkg::M_SQ:   state_nxt = pfn_pkg::S_SQRT;
            default:         state_nxt = pfn_pkg::S_ABS;
          endcase
        end
      end
      pfn_pkg::S_ABS:   state_nxt = pfn_pkg::S_SCALE;
      pfn_pkg::S_SCALE: begin
        priority if (all_zero)        state_nxt = pfn_pkg::S_FIN;
        else if (any_hi || !any_29)   state_nxt = pfn_pkg::S_SCALE;
        else                          state_nxt = pfn_pkg::S_MUL;
      end
      pfn_pkg::S_SQRT: begin
        if (sbit_r[0]) state_nxt = pfn_pkg::S_DINIT;
      end
      pfn_pkg::S_DINIT: state_nxt = pfn_pkg::S_DIV;
      pfn_pkg::S_DIV: begin
        if (bcnt_r == '0) begin
          state_nxt = (ci_r == 2'd2) ? pfn_pkg::S_FIN : pfn_pkg::S_DINIT;
        end
      end
      pfn_pkg::S_FIN: begin
        if (fin_go) state_nxt = pfn_pkg::S_IDLE;
      end
      default: state_nxt = pfn_pkg::S_IDLE;
    endcase
  end

  // -------------------------------------------------------------------------
  // Datapath and control registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfn_pkg::S_IDLE;
      mode_r      <= pfn_pkg::M_EDGE;
      step_r      <= '0;
      ci_r        <= 2'd0;
      count_r     <= '0;
      abort_r     <= 1'b0;
      wind_r      <= 1'b1;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) sum_r[i] <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) wind_r <= cfg_data;

      // hold the result word until taken
      if (fin_go) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      unique case (state_r)
        pfn_pkg::S_IDLE: begin
          if (in_acc) begin
            unique case (act)
              pfn_pkg::ACT_START: begin
                // drop any face in progress
                abort_r <= 1'b0;
                count_r <= '0;
                for (int i = 0; i < 3; i++) sum_r[i] <= '0;
              end
              pfn_pkg::ACT_END: begin
                if (!abort_r) begin
                  step_r <= '0;
                  priority if (count_r < pfn_pkg::TRI_COUNT) begin
                    for (int i = 0; i < 3; i++) res_r[i] <= '0;
                    stat_r <= pfn_pkg::ST_SHORT;
                  end else if (count_r == pfn_pkg::TRI_COUNT) begin
                    mode_r     <= pfn_pkg::M_TRI;
                    face_tri_r <= 1'b1;
                    for (int i = 0; i < 3; i++) sum_r[i] <= '0;
                  end else begin
                    mode_r     <= pfn_pkg::M_CLOSE;
                    face_tri_r <= 1'b0;
                  end
                end
              end
              default: ;
            endcase
          end
        end

        pfn_pkg::S_READ: begin
          cur_r <= rd_v;
          if (count_r < pfn_pkg::TRI_COUNT) first_r[count_r[1:0]] <= rd_v;
          if (count_r == '0) begin
            prev_r  <= rd_v;
            count_r <= count_r + 1'b1;
          end else begin
            mode_r <= pfn_pkg::M_EDGE;
            step_r <= '0;
          end
        end

        pfn_pkg::S_MUL: begin
          prod_r     <= mul_a * mul_b;
          pend_tgt_r <= mul_tgt;
          pend_sub_r <= mul_sub;
          step_r     <= step_r + 1'b1;
          if (step_r != '0) begin
            if (mode_r == pfn_pkg::M_SQ) begin
              sq_r <= sq_r + unsigned'(prod_r);
            end else if (pend_sub_r) begin
              sum_r[pend_tgt_r] <= sum_r[pend_tgt_r] - prod_r;
            end else begin
              sum_r[pend_tgt_r] <= sum_r[pend_tgt_r] + prod_r;
            end
          end
          if (step_r == mul_last) begin
            if (mode_r == pfn_pkg::M_EDGE) begin
              prev_r  <= cur_r;
              count_r <= count_r + 1'b1;
            end
            root_r <= '0;
            sbit_r <= AW64'(1) << 62;
          end
        end

        pfn_pkg::S_ABS: begin
          for (int i = 0; i < 3; i++) begin
            neg_r[i] <= vabs[i][AW64-1];
            mag_r[i] <= vabs[i][AW64-1] ? unsigned'(-vabs[i]) : unsigned'(vabs[i]);
          end
        end

        pfn_pkg::S_SCALE: begin
          // bring the largest magnitude into [2^29, 2^30)
          priority if (all_zero) begin
            res_r[0] <= degen_x;
            res_r[1] <= '0;
            res_r[2] <= '0;
            stat_r   <= pfn_pkg::ST_DEGEN;
          end else if (any_hi) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
          end else if (!any_29) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 1;
          end else begin
            mode_r <= pfn_pkg::M_SQ;
            step_r <= '0;
            sq_r   <= '0;
          end
        end

        pfn_pkg::S_SQRT: begin
          if (sqrt_ge) sq_r <= sq_r - (root_r + sbit_r);
          root_r <= root_step;
          sbit_r <= sbit_r >> 2;
          if (sbit_r[0]) begin
            len_r <= root_step[31:0];
            ci_r  <= 2'd0;
          end
        end

        pfn_pkg::S_DINIT: begin
          rem_r  <= (AW64'(mag_sel[29:0]) << NW) + AW64'(len_r);
          dsh_r  <= (AW64'(len_r) << 1) << (QW - 1);
          q_r    <= '0;
          bcnt_r <= BCW'(QW - 1);
        end

        pfn_pkg::S_DIV: begin
          if (div_ge) rem_r <= rem_r - dsh_r;
          dsh_r  <= dsh_r >> 1;
          q_r    <= qf;
          bcnt_r <= bcnt_r - 1'b1;
          if (bcnt_r == '0) begin
            res_r[ci_r] <= res_val;
            ci_r        <= ci_r + 1'b1;
            if (ci_r == 2'd2) stat_r <= pfn_pkg::ST_VALID;
          end
        end

        pfn_pkg::S_FIN: begin
          if (fin_go) begin
            out_x_r    <= res_r[0];
            out_y_r    <= res_r[1];
            out_z_r    <= res_r[2];
            out_stat_r <= stat_r;
            count_r    <= '0;
            for (int i = 0; i < 3; i++) sum_r[i] <= '0;
            // a short face aborts the rest of the shape
            if (stat_r == pfn_pkg::ST_SHORT) abort_r <= 1'b1;
          end
        end

        default: ;
      endcase
    end
  end

endmodule

FILE: src/pfn_checker.sv
// ---------------------------------------------------------------------------
// pfn_checker
// Port-level checks of the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "polygon_face_normal_assert.svh"

module pfn_checker #(
  parameter int NORMAL_WIDTH = pfn_pkg::DEF_NORMAL_WIDTH
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [NORMAL_WIDTH-1:0] out_normal_x,
  input logic [NORMAL_WIDTH-1:0] out_normal_y,
  input logic [NORMAL_WIDTH-1:0] out_normal_z,
  input logic [1:0]              out_face_status
);

  `PFN_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `PFN_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_normal_x) && $stable(out_normal_y) && $stable(out_normal_z) && $stable(out_face_status))
  `PFN_ASSERT_IMP(a_short_zero, clk, rst_n, out_valid && out_face_status == pfn_pkg::ST_SHORT, out_normal_x == '0 && out_normal_y == '0 && out_normal_z == '0)
  `PFN_ASSERT_IMP(a_degen_axis, clk, rst_n, out_valid && out_face_status == pfn_pkg::ST_DEGEN, out_normal_y == '0 && out_normal_z == '0 && out_normal_x != '0)

endmodule

bind polygon_face_normal pfn_checker #(
  .NORMAL_WIDTH (NORMAL_WIDTH)
) u_pfn_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_normal_x    (out_ch.normal_x),
  .out_normal_y    (out_ch.normal_y),
  .out_normal_z    (out_ch.normal_z),
  .out_face_status (out_ch.face_status)
);

FILE: tb/polygon_face_normal_tb.sv
// ---------------------------------------------------------------------------
// polygon_face_normal_tb
// Streams coordinate loads, shape starts, face vertices and face ends into
// the block and checks each normal word against an in-bench face model.
// ---------------------------------------------------------------------------
module polygon_face_normal_tb;

  localparam int DEPTH      = 1024;
  localparam int NW         = 16;
  localparam int DRAIN_WAIT = 300;   // covers the longest face end
  localparam int IDLE_LIMIT = 4000;  // cycles with no word moving
  localparam int HOLD_LEN   = 700;

  typedef struct {
    logic signed [NW-1:0] nx, ny, nz;
    pfn_pkg::status_t     st;
  } normal_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic cfg_data = 0;

  pfn_in_if  in_ch ();
  pfn_out_if out_ch ();

  polygon_face_normal dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // Face model state
  longint       store_xyz [DEPTH][3];
  bit           loaded [DEPTH];
  int           loaded_slots [$];
  longint       corner [3][3];
  longint       prev_v [3];
  longint       nsum [3];
  int unsigned  face_cnt;
  bit           aborted;
  bit           ccw;

  normal_t      normal_queue [$];
  int           fail_cnt, face_checked, words_sent, idle_cycles;
  int           burst_left;
  int           hold_left;
  bit           hold_trig;

  initial begin
    forever #6 clk = ~clk;
  end

  // Drive every input to a known value from time zero.
  initial begin
    in_ch.valid = 0;
    in_ch.action = pfn_pkg::ACT_LOAD;
    in_ch.vertex_index = 0;
    in_ch.coord_x = 0;
    in_ch.coord_y = 0;
    in_ch.coord_z = 0;
    out_ch.ready = 0;
  end

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Scale to unit length in Q1.15; return 0 for the zero vector.
  function automatic bit unit_vec(input longint v[3], output longint r[3]);
    longint unsigned mag [3];
    longint unsigned mx, sq, len, q;
    bit neg [3];
    longint val;
    mx = 0;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? longint'(-v[i]) : longint'(v[i]);
      if (mag[i] > mx) mx = mag[i];
    end
    if (mx == 0) return 0;
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
      mx >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
      mx <<= 1;
    end
    for (int i = 0; i < 3; i++) sq += mag[i] * mag[i];
    len = root64(sq);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << NW) + len) / (2 * len);
      val = longint'(q);
      if (neg[i]) begin
        val = -val;
        if (val < -32768) val = -32768;
      end else if (val > 32767) begin
        val = 32767;
      end
      r[i] = val;
    end
    return 1;
  endfunction

  function automatic void add_edge(input longint p[3], input longint q[3]);
    nsum[0] += (p[1] - q[1]) * (p[2] + q[2]);
    nsum[1] += (p[2] - q[2]) * (p[0] + q[0]);
    nsum[2] += (p[0] - q[0]) * (p[1] + q[1]);
  endfunction

  function automatic void push_normal(longint x, longint y, longint z,
                                      pfn_pkg::status_t st);
    normal_t n;
    n.nx = x[NW-1:0];
    n.ny = y[NW-1:0];
    n.nz = z[NW-1:0];
    n.st = st;
    normal_queue.push_back(n);
  endfunction

  // Advance the face model by one accepted word.
  function automatic void face_normal_predict(pfn_pkg::action_t act, int slot,
      logic signed [23:0] cx, logic signed [23:0] cy, logic signed [23:0] cz);
    longint a [3], b [3], n [3], r [3], p [3];
    if (act == pfn_pkg::ACT_LOAD) begin
      store_xyz[slot][0] = cx;
      store_xyz[slot][1] = cy;
      store_xyz[slot][2] = cz;
      if (!loaded[slot]) loaded_slots.push_back(slot);
      loaded[slot] = 1;
      return;
    end
    if (act == pfn_pkg::ACT_START) begin
      aborted = 0;
      face_cnt = 0;
      nsum = '{0, 0, 0};
      return;
    end
    if (aborted) return;
    if (act == pfn_pkg::ACT_VERTEX) begin
      if (face_cnt >= 2047) return;
      for (int i = 0; i < 3; i++) p[i] = store_xyz[slot][i];
      if (face_cnt < 3) corner[face_cnt] = p;
      if (face_cnt > 0) add_edge(prev_v, p);
      prev_v = p;
      face_cnt++;
      return;
    end
    // face end
    if (face_cnt < 3) begin
      push_normal(0, 0, 0, pfn_pkg::ST_SHORT);
      aborted = 1;
    end else if (face_cnt == 3) begin
      for (int i = 0; i < 3; i++) begin
        a[i] = ccw ? corner[2][i] - corner[1][i] : corner[0][i] - corner[1][i];
        b[i] = ccw ? corner[0][i] - corner[1][i] : corner[2][i] - corner[1][i];
      end
      n[0] = a[1] * b[2] - a[2] * b[1];
      n[1] = a[2] * b[0] - a[0] * b[2];
      n[2] = a[0] * b[1] - a[1] * b[0];
      if (unit_vec(n, r)) push_normal(r[0], r[1], r[2], pfn_pkg::ST_VALID);
      else push_normal(32767, 0, 0, pfn_pkg::ST_DEGEN);
    end else begin
      add_edge(prev_v, corner[0]);
      for (int i = 0; i < 3; i++) n[i] = ccw ? nsum[i] : -nsum[i];
      if (unit_vec(n, r)) push_normal(r[0], r[1], r[2], pfn_pkg::ST_VALID);
      else push_normal(ccw ? 32767 : -32768, 0, 0, pfn_pkg::ST_DEGEN);
    end
    face_cnt = 0;
    nsum = '{0, 0, 0};
  endfunction

  // Offer one word, hold it until accepted, then maybe open a gap.
  task automatic send_word(pfn_pkg::action_t act, int slot = 0,
      logic signed [23:0] cx = 0, logic signed [23:0] cy = 0,
      logic signed [23:0] cz = 0);
    int gap;
    in_ch.valid <= 1;
    in_ch.action <= act;
    in_ch.vertex_index <= slot[9:0];
    in_ch.coord_x <= cx;
    in_ch.coord_y <= cy;
    in_ch.coord_z <= cz;
    do @(posedge clk); while (!in_ch.ready);
    face_normal_predict(act, slot, cx, cy, cz);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
      gap = $urandom_range(1, 5);
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic input_idle();
    in_ch.valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    input_idle();
    while (normal_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Write the winding register with the block quiet.
  task automatic set_winding(bit v);
    drain_results();
    cfg_we <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    ccw = v;
  endtask

  function automatic logic signed [23:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 24'sh800000;
      1: return 24'sh7FFFFF;
      2: return $urandom_range(0, 1) ? 24'sd0 : -24'sd1;
      3: return 24'($signed($urandom_range(0, 2000)) - 1000);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic int any_loaded();
    return loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
  endfunction

  task automatic load_slot(int slot);
    send_word(pfn_pkg::ACT_LOAD, slot, pick_coord(), pick_coord(), pick_coord());
  endtask

  task automatic send_face(int nverts);
    for (int i = 0; i < nverts; i++) send_word(pfn_pkg::ACT_VERTEX, any_loaded());
    send_word(pfn_pkg::ACT_END);
  endtask

  // Directed: extremes, triangles, polygons, degenerate and short faces.
  task automatic test_directed();
    send_word(pfn_pkg::ACT_LOAD, 0, 24'sh800000, 24'sh7FFFFF, 24'sd0);
    send_word(pfn_pkg::ACT_LOAD, 1023, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
    send_word(pfn_pkg::ACT_LOAD, 1, 24'sd0, 24'sd0, 24'sd0);
    send_word(pfn_pkg::ACT_LOAD, 2, 24'sd65536, 24'sd0, 24'sd0);
    send_word(pfn_pkg::ACT_LOAD, 3, 24'sd0, 24'sd65536, 24'sd0);
    send_word(pfn_pkg::ACT_LOAD, 4, 24'sd65536, 24'sd65536, 24'sd0);
    send_word(pfn_pkg::ACT_START);
    send_word(pfn_pkg::ACT_VERTEX, 1);
    send_word(pfn_pkg::ACT_VERTEX, 2);
    send_word(pfn_pkg::ACT_VERTEX, 3);
    send_word(pfn_pkg::ACT_END);
    // quad, then extremes triangle
    send_word(pfn_pkg::ACT_VERTEX, 1);
    send_word(pfn_pkg::ACT_VERTEX, 2);
    send_word(pfn_pkg::ACT_VERTEX, 4);
    send_word(pfn_pkg::ACT_VERTEX, 3);
    send_word(pfn_pkg::ACT_END);
    send_word(pfn_pkg::ACT_VERTEX, 0);
    send_word(pfn_pkg::ACT_VERTEX, 1023);
    send_word(pfn_pkg::ACT_VERTEX, 1);
    send_word(pfn_pkg::ACT_END);
    // degenerate triangle and polygon
    send_word(pfn_pkg::ACT_VERTEX, 2);
    send_word(pfn_pkg::ACT_VERTEX, 2);
    send_word(pfn_pkg::ACT_VERTEX, 2);
    send_word(pfn_pkg::ACT_END);
    for (int i = 0; i < 4; i++) send_word(pfn_pkg::ACT_VERTEX, 4);
    send_word(pfn_pkg::ACT_END);
    // short face aborts; ignored words until a start, loads still act
    send_word(pfn_pkg::ACT_VERTEX, 3);
    send_word(pfn_pkg::ACT_END);
    send_word(pfn_pkg::ACT_VERTEX, 2);
    send_word(pfn_pkg::ACT_END);
    send_word(pfn_pkg::ACT_LOAD, 5, 24'sd0, 24'sd0, 24'sd65536);
    send_word(pfn_pkg::ACT_START);
    send_word(pfn_pkg::ACT_END);
    send_word(pfn_pkg::ACT_START);
  endtask

  task automatic test_clockwise();
    set_winding(0);
    send_word(pfn_pkg::ACT_START);
    send_word(pfn_pkg::ACT_VERTEX, 1);
    send_word(pfn_pkg::ACT_VERTEX, 2);
    send_word(pfn_pkg::ACT_VERTEX, 3);
    send_word(pfn_pkg::ACT_END);
    send_word(pfn_pkg::ACT_VERTEX, 1);
    send_word(pfn_pkg::ACT_VERTEX, 2);
    send_word(pfn_pkg::ACT_VERTEX, 4);
    send_word(pfn_pkg::ACT_VERTEX, 5);
    send_word(pfn_pkg::ACT_END);
    for (int i = 0; i < 5; i++) send_word(pfn_pkg::ACT_VERTEX, 3);
    send_word(pfn_pkg::ACT_END);
    send_word(pfn_pkg::ACT_VERTEX, 2);
    send_word(pfn_pkg::ACT_VERTEX, 2);
    send_word(pfn_pkg::ACT_VERTEX, 2);
    send_word(pfn_pkg::ACT_END);
    // a vertex read fixes the face even if the slot is reloaded mid-face
    send_word(pfn_pkg::ACT_VERTEX, 5);
    send_word(pfn_pkg::ACT_VERTEX, 2);
    send_word(pfn_pkg::ACT_LOAD, 5, 24'sd65536, 24'sd65536, 24'sd65536);
    send_word(pfn_pkg::ACT_VERTEX, 3);
    send_word(pfn_pkg::ACT_END);
  endtask

  // Hold the receiver off while faces keep coming, so the input backs up.
  task automatic test_backpressure();
    send_word(pfn_pkg::ACT_START);
    hold_trig = 1;
    for (int i = 0; i < 5; i++) send_face(3 + (i % 2));
  endtask

  // Run one long polygon through the Newell path.
  task automatic test_long_face();
    send_word(pfn_pkg::ACT_START);
    for (int i = 0; i < 60; i++) send_word(pfn_pkg::ACT_VERTEX, 2 + (i % 3));
    send_word(pfn_pkg::ACT_END);
  endtask

  task automatic test_random(int n_words);
    int target, r;
    target = words_sent + n_words;
    while (words_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        load_slot($urandom_range(0, DEPTH - 1));
      end else if (r < 20) begin
        send_word(pfn_pkg::ACT_START);
      end else if (r < 24) begin
        send_face($urandom_range(0, 2));
      end else if (r < 28) begin
        send_word(pfn_pkg::action_t'($urandom_range(1, 3)), any_loaded());
      end else begin
        if (aborted) send_word(pfn_pkg::ACT_START);
        send_face($urandom_range(0, 1) ? 3 : $urandom_range(4, 9));
      end
    end
  endtask

  // Receiver: stall on a pattern that moves through always-ready, random and mostly stalled phases, plus a long hold.
  always @(posedge clk) begin
    if (hold_trig) begin
      hold_trig = 0;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 0;
    end else begin
      case (($time / 768) % 3)
        0: out_ch.ready <= 1;
        1: out_ch.ready <= $urandom_range(0, 1);
        default: out_ch.ready <= $urandom_range(0, 3) == 0;
      endcase
    end
  end

  // Compare each accepted normal word with the oldest expectation.
  always @(posedge clk) begin
    normal_t exp_n;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (normal_queue.size() == 0) begin
        $display("%0t: unexpected normal word %0d %0d %0d status %0d", $time,
                 out_ch.normal_x, out_ch.normal_y, out_ch.normal_z, out_ch.face_status);
        fail_cnt++;
      end else begin
        exp_n = normal_queue.pop_front();
        face_checked++;
        if (out_ch.normal_x !== exp_n.nx || out_ch.normal_y !== exp_n.ny ||
            out_ch.normal_z !== exp_n.nz || out_ch.face_status !== exp_n.st) begin
          $display("%0t: normal mismatch exp %0d %0d %0d st %0d got %0d %0d %0d st %0d",
                   $time, exp_n.nx, exp_n.ny, exp_n.nz, exp_n.st, out_ch.normal_x,
                   out_ch.normal_y, out_ch.normal_z, out_ch.face_status);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: drop the run if no word moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d normal words still due", $time, normal_queue.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    ccw = 1;
    aborted = 0;
    face_cnt = 0;
    nsum = '{0, 0, 0};
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_clockwise();
    set_winding(1);
    test_backpressure();
    for (int i = 0; i < 40; i++) load_slot($urandom_range(0, DEPTH - 1));
    test_random(250);
    set_winding(0);
    test_random(250);
    set_winding(1);
    test_long_face();
    test_random(250);
    drain_results();
    $display("Covered %0d words in, %0d normal words checked, both windings,", words_sent,
             face_checked);
    $display("degenerate, short, long and stalled faces.");
    if (fail_cnt == 0 && normal_queue.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/pfn_pkg.sv
src/pfn_if.sv
src/pfn_store.sv
src/polygon_face_normal.sv
src/pfn_checker.sv
tb/polygon_face_normal_tb.sv
